FILE: design/imm_pkg.sv
package imm_pkg;

   // sizes of the matrix store and of the fields
   localparam int MAX_DIM = 8;
   localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int DIM_W   = 4;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int ACC_W   = 35;
   localparam int CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_SECOND = 2'd2;

   // tag that travels with each multiply-accumulate step
   typedef struct packed {
      logic             first;
      logic             last;
      logic             final_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   // controller to datapath
   typedef struct packed {
      logic              wr_en;
      logic              wr_second;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      tag_type           tag;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;
   } status_type;

endpackage

FILE: design/imm_ctrl.sv
module imm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          csr_we,
   input  logic [imm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [imm_pkg::DIM_W-1:0]     csr_data,
   output imm_pkg::cmd_type              cmd,
   input  imm_pkg::status_type           status
);

   localparam logic [1:0] ST_LOAD_A = 2'd0;
   localparam logic [1:0] ST_LOAD_B = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;
   localparam logic [1:0] ST_DRAIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [imm_pkg::DIM_W-1:0] rows_ff, rows_in;
   logic [imm_pkg::DIM_W-1:0] inner_ff, inner_in;
   logic [imm_pkg::DIM_W-1:0] cols_ff, cols_in;
   logic [imm_pkg::IDX_W-1:0] i_ff, i_in;
   logic [imm_pkg::IDX_W-1:0] j_ff, j_in;
   logic [imm_pkg::IDX_W-1:0] k_ff, k_in;
   logic [imm_pkg::IDX_W-1:0] nr_max, nk_max, nc_max;
   logic [imm_pkg::IDX_W-1:0] row_max, col_max;
   logic cfg_hit, take, i_end, j_end, k_end;

   // clamp a size register to 1..MAX_DIM and give its largest index
   function automatic logic [imm_pkg::IDX_W-1:0] max_index(
      input logic [imm_pkg::DIM_W-1:0] v);
      logic [imm_pkg::DIM_W-1:0] d;
      begin
         d = v;
         if (v == '0) begin
            d = imm_pkg::DIM_W'(1);
         end else if (v > imm_pkg::DIM_W'(imm_pkg::MAX_DIM)) begin
            d = imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
         end
         max_index = imm_pkg::IDX_W'(d - imm_pkg::DIM_W'(1));
      end
   endfunction

   assign nr_max = max_index(rows_ff);
   assign nk_max = max_index(inner_ff);
   assign nc_max = max_index(cols_ff);

   assign busy    = (state_ff == ST_RUN) || (state_ff == ST_DRAIN);
   assign take    = start && !busy;
   assign cfg_hit = csr_we && ((csr_index == imm_pkg::CSR_ROWS_FIRST) ||
                               (csr_index == imm_pkg::CSR_INNER_SIZE) ||
                               (csr_index == imm_pkg::CSR_COLS_SECOND));

   // during loads i/j walk the row and column of the matrix being loaded
   assign row_max = (state_ff == ST_LOAD_A) ? nr_max : nk_max;
   assign col_max = (state_ff == ST_LOAD_A) ? nk_max : nc_max;

   assign k_end = (k_ff == nk_max);
   assign j_end = (j_ff == nc_max);
   assign i_end = (i_ff == nr_max);

   // issue store writes during loads and reads during the run
   always_comb begin
      cmd                = '0;
      cmd.wr_en          = take;
      cmd.wr_second      = (state_ff == ST_LOAD_B);
      cmd.wr_addr        = {i_ff, j_ff};
      cmd.rd_en          = (state_ff == ST_RUN);
      cmd.rd_addr_a      = {i_ff, k_ff};
      cmd.rd_addr_b      = {k_ff, j_ff};
      cmd.tag.first      = (k_ff == '0);
      cmd.tag.last       = k_end;
      cmd.tag.final_elem = k_end && j_end && i_end;
      cmd.tag.row        = i_ff;
      cmd.tag.col        = j_ff;
   end

   // sequence loads, then sweep i, j, k one step a cycle
   always_comb begin
      state_in = state_ff;
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_LOAD_A, ST_LOAD_B: begin
            if (take) begin
               if (j_ff == col_max) begin
                  j_in = '0;
                  if (i_ff == row_max) begin
                     i_in     = '0;
                     state_in = (state_ff == ST_LOAD_A) ? ST_LOAD_B : ST_RUN;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_RUN: begin
            if (k_end) begin
               k_in = '0;
               if (j_end) begin
                  j_in = '0;
                  if (i_end) begin
                     i_in     = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.done) begin
               state_in = ST_LOAD_A;
            end
         end
         default: state_in = ST_LOAD_A;
      endcase
      // a size write restarts loading from the first word of A
      if (cfg_hit) begin
         state_in = ST_LOAD_A;
         i_in     = '0;
         j_in     = '0;
         k_in     = '0;
         unique case (csr_index)
            imm_pkg::CSR_ROWS_FIRST:  rows_in  = csr_data;
            imm_pkg::CSR_INNER_SIZE:  inner_in = csr_data;
            imm_pkg::CSR_COLS_SECOND: cols_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD_A;
         rows_ff  <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
         inner_ff <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
         cols_ff  <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // a store is never written and read in the same cycle
   a_no_wr_rd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.rd_en))
      else $error("store write and read issued together");

   // the last read of a run hands over to the drain wait
   a_run_to_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.tag.final_elem && !cfg_hit) |=> (state_ff == ST_DRAIN))
      else $error("run did not end after the final read");

   // the final result frees the block for the next load
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      status.done |=> !busy)
      else $error("block still busy after the final result");

endmodule

FILE: design/imm_datapath.sv
module imm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [imm_pkg::ELEM_W-1:0] req_element,
   input  imm_pkg::cmd_type                  cmd,
   output imm_pkg::status_type               status,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_out_row,
   output logic [2:0]                        rsp_out_col,
   output logic signed [imm_pkg::ACC_W-1:0]  rsp_product_value,
   output logic                              rsp_last_result
);

   logic signed [imm_pkg::ELEM_W-1:0] first_store_ff  [imm_pkg::DEPTH];
   logic signed [imm_pkg::ELEM_W-1:0] second_store_ff [imm_pkg::DEPTH];

   logic signed [imm_pkg::ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic                              s1_valid_ff;
   imm_pkg::tag_type                  s1_tag_ff;
   logic signed [imm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                              s2_valid_ff;
   imm_pkg::tag_type                  s2_tag_ff;
   logic signed [imm_pkg::ACC_W-1:0]  acc_ff, acc_in, prod_ext;
   logic                              out_valid_ff, out_valid_in;
   logic                              out_last_ff;
   logic [imm_pkg::IDX_W-1:0]         out_row_ff, out_col_ff;

   // write the loaded word into its store
   always_ff @(posedge clock) begin
      if (cmd.wr_en && !cmd.wr_second) begin
         first_store_ff[cmd.wr_addr] <= req_element;
      end
      if (cmd.wr_en && cmd.wr_second) begin
         second_store_ff[cmd.wr_addr] <= req_element;
      end
   end

   // read one A and one B word a cycle
   always_ff @(posedge clock) begin
      a_rd_ff   <= first_store_ff[cmd.rd_addr_a];
      b_rd_ff   <= second_store_ff[cmd.rd_addr_b];
      s1_tag_ff <= cmd.tag;
   end

   // multiply, then accumulate over k
   assign prod_in  = a_rd_ff * b_rd_ff;
   assign prod_ext = imm_pkg::ACC_W'(prod_ff);
   assign acc_in   = s2_tag_ff.first ? prod_ext : acc_ff + prod_ext;

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      s2_tag_ff <= s1_tag_ff;
      if (s2_valid_ff) begin
         acc_ff     <= acc_in;
         out_row_ff <= s2_tag_ff.row;
         out_col_ff <= s2_tag_ff.col;
         out_last_ff <= s2_tag_ff.final_elem;
      end
   end

   // strobe the word after its last product is added
   assign out_valid_in = s2_valid_ff && s2_tag_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.rd_en;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_row       = 3'(out_row_ff);
   assign rsp_out_col       = 3'(out_col_ff);
   assign rsp_product_value = acc_ff;
   assign rsp_last_result   = out_last_ff;
   assign status.done       = out_valid_ff && out_last_ff;

   // every result word closes a k sweep that passed the multiplier
   a_out_from_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s2_valid_ff && s2_tag_ff.last))
      else $error("result word without a finished dot product");

   // a read issued passes through s1 and then reaches the accumulator at s2
   a_pipe_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> ##1 s2_valid_ff)
      else $error("read lost in the multiply pipeline");

endmodule

FILE: design/integer_matrix_multiply.sv
// Signed integer matrix multiplier, C = A * B. Load A (rows_first x
// inner_size) and then B (inner_size x cols_second) one 16-bit word per
// start pulse, each row-major; a load word is taken whenever
// busy is low. After the last word of B the block raises busy and streams
// one multiply-accumulate a cycle from the two element stores, whose single
// read port each sets the rate, and a result word appears on rsp_valid for
// exactly one cycle, with row, column and the 35-bit exact sum; the receiver
// cannot stall, so it must take each word as it comes. rsp_last_result marks
// the final word, after which busy drops. Sizes are clamped to 1..8; a size
// write restarts loading from the first word of A and must be made while
// the block is not busy.
module integer_matrix_multiply (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [imm_pkg::ELEM_W-1:0] req_element,
   input  logic                              csr_we,
   input  logic [imm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imm_pkg::DIM_W-1:0]         csr_data,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_out_row,
   output logic [2:0]                        rsp_out_col,
   output logic signed [imm_pkg::ACC_W-1:0]  rsp_product_value,
   output logic                              rsp_last_result
);

   imm_pkg::cmd_type    cmd;
   imm_pkg::status_type status;

   imm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

   imm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_element       (req_element),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

FILE: dv/matmul_checker.sv
`timescale 1ns / 100ps

// Watches the load, result and register channels of the matrix multiplier,
// predicts every product word and compares it with what the block emits.
module matmul_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic signed [imm_pkg::ELEM_W-1:0] req_element,
   input  logic                              csr_we,
   input  logic [imm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imm_pkg::DIM_W-1:0]         csr_data,
   input  logic                              rsp_valid,
   input  logic [2:0]                        rsp_out_row,
   input  logic [2:0]                        rsp_out_col,
   input  logic signed [imm_pkg::ACC_W-1:0]  rsp_product_value,
   input  logic                              rsp_last_result,
   output int                                fail_count,
   output int                                pending
);
   import imm_pkg::*;

   typedef struct packed {
      logic [2:0]              row;
      logic [2:0]              col;
      logic signed [ACC_W-1:0] value;
      logic                    last;
   } product_type;

   // predicted product words, oldest first
   product_type product_queue[$];

   // shadow of the size registers and of the element stores
   logic [DIM_W-1:0]         rows_reg;
   logic [DIM_W-1:0]         inner_reg;
   logic [DIM_W-1:0]         cols_reg;
   logic signed [ELEM_W-1:0] first_mat[DEPTH];
   logic signed [ELEM_W-1:0] second_mat[DEPTH];
   int                       fill_pos;
   logic                     filling_second;
   int                       mismatch_count;

   initial mismatch_count = 0;

   function automatic int clamp_size(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < 50)
         $display("[%0t] ERROR: %s", $time, what);
      mismatch_count++;
   endtask

   // store one loaded word; after the last word of B queue the whole product
   task automatic load_element(logic signed [ELEM_W-1:0] e);
      int          nr;
      int          nk;
      int          nc;
      longint      acc;
      product_type p;
      nr = clamp_size(rows_reg);
      nk = clamp_size(inner_reg);
      nc = clamp_size(cols_reg);
      if (!filling_second) begin
         first_mat[(fill_pos / nk) * MAX_DIM + (fill_pos % nk)] = e;
         fill_pos++;
         if (fill_pos >= nr * nk) begin
            fill_pos = 0;
            filling_second = 1'b1;
         end
      end else begin
         second_mat[(fill_pos / nc) * MAX_DIM + (fill_pos % nc)] = e;
         fill_pos++;
         if (fill_pos >= nk * nc) begin
            fill_pos = 0;
            filling_second = 1'b0;
            for (int i = 0; i < nr; i++) begin
               for (int j = 0; j < nc; j++) begin
                  acc = 0;
                  for (int k = 0; k < nk; k++)
                     acc += longint'(first_mat[i * MAX_DIM + k]) *
                            longint'(second_mat[k * MAX_DIM + j]);
                  p.row   = i[2:0];
                  p.col   = j[2:0];
                  p.value = acc[ACC_W-1:0];
                  p.last  = (i == nr - 1) && (j == nc - 1);
                  product_queue.push_back(p);
               end
            end
         end
      end
   endtask

   // compare one emitted word with the oldest prediction
   task automatic check_product();
      product_type p;
      if (product_queue.size() == 0) begin
         report_mismatch($sformatf("unexpected word row %0d col %0d value %0d",
                                   rsp_out_row, rsp_out_col, rsp_product_value));
         return;
      end
      p = product_queue.pop_front();
      if (rsp_out_row !== p.row)
         report_mismatch($sformatf("row %0d, expected %0d", rsp_out_row, p.row));
      if (rsp_out_col !== p.col)
         report_mismatch($sformatf("col %0d, expected %0d", rsp_out_col, p.col));
      if (rsp_product_value !== p.value)
         report_mismatch($sformatf("value %0d at (%0d,%0d), expected %0d",
                                   rsp_product_value, p.row, p.col, p.value));
      if (rsp_last_result !== p.last)
         report_mismatch($sformatf("last %b at (%0d,%0d), expected %b",
                                   rsp_last_result, p.row, p.col, p.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rows_reg       = 4'd8;
         inner_reg      = 4'd8;
         cols_reg       = 4'd8;
         fill_pos       = 0;
         filling_second = 1'b0;
         product_queue.delete();
      end else begin
         if (rsp_valid)
            check_product();
         // a size write restarts the load at the first word of A
         if (csr_we) begin
            case (csr_index)
               CSR_ROWS_FIRST: begin
                  rows_reg       = csr_data;
                  fill_pos       = 0;
                  filling_second = 1'b0;
               end
               CSR_INNER_SIZE: begin
                  inner_reg      = csr_data;
                  fill_pos       = 0;
                  filling_second = 1'b0;
               end
               CSR_COLS_SECOND: begin
                  cols_reg       = csr_data;
                  fill_pos       = 0;
                  filling_second = 1'b0;
               end
               default: ;
            endcase
         end
         if (start && !busy)
            load_element(req_element);
      end
      pending    <= product_queue.size();
      fail_count <= mismatch_count;
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

// Drives matrix pairs and size writes into the multiplier; the checker
// beside it predicts and compares every product word.
module tb_top;
   import imm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int WORD_TARGET    = 390;

   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       start       = 1'b0;
   logic signed [ELEM_W-1:0]   req_element = '0;
   logic                       csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index   = '0;
   logic [DIM_W-1:0]           csr_data    = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [2:0]                 rsp_out_row;
   logic [2:0]                 rsp_out_col;
   logic signed [ACC_W-1:0]    rsp_product_value;
   logic                       rsp_last_result;
   int                         fail_count;
   int                         pending;
   int                         idle_cycles = 0;
   int                         words_sent  = 0;
   logic                       gaps_on     = 1'b1;

   integer_matrix_multiply u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_element       (req_element),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_result   (rsp_last_result)
   );

   matmul_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_element       (req_element),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_result   (rsp_last_result),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int dim_in_use(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // mostly random words, with the extremes mixed in
   function automatic logic signed [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         4: return ELEM_W'($signed($urandom_range(0, 16)) - 8);
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // offer one load word, idling first now and then, and hold until taken
   task automatic send_word(logic signed [ELEM_W-1:0] v);
      if (gaps_on && $urandom_range(0, 99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start       <= 1'b1;
      req_element <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   // drop start, wait until every word is out and the block is idle
   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      quiesce();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      logic [DIM_W-1:0] rv;
      logic [DIM_W-1:0] kv;
      logic [DIM_W-1:0] cv;
      int               phase;
      int               total;
      int               cut;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 1x1x1: most negative squared
      write_reg(CSR_ROWS_FIRST, 4'd1);
      write_reg(CSR_INNER_SIZE, 4'd1);
      write_reg(CSR_COLS_SECOND, 4'd1);
      send_word(16'sh8000);
      send_word(16'sh8000);

      // a write to the unused index mid-load leaves the load alone
      send_word(16'sh7FFF);
      write_reg(CSR_SPARE, 4'hF);
      send_word(16'sh8000);

      // zero and oversized sizes clamp: 1x8 times 8x1, largest sum
      write_reg(CSR_ROWS_FIRST, 4'd0);
      write_reg(CSR_INNER_SIZE, 4'd12);
      write_reg(CSR_COLS_SECOND, 4'd0);
      repeat (16) send_word(16'sh8000);

      // a size write mid-load restarts from the first word of A
      write_reg(CSR_ROWS_FIRST, 4'd2);
      write_reg(CSR_INNER_SIZE, 4'd1);
      write_reg(CSR_COLS_SECOND, 4'd2);
      send_word(16'sh1234);
      write_reg(CSR_INNER_SIZE, 4'd1);
      send_word(16'sh7FFF);
      send_word(16'shFFFF);
      send_word(16'sh8000);
      send_word(16'sh0005);

      // random phases: new sizes, then a few matrix pairs each
      phase = 0;
      while (words_sent < WORD_TARGET) begin
         if (phase == 0) begin
            rv = 4'd8; kv = 4'd8; cv = 4'd8;
         end else if (phase == 1) begin
            rv = 4'd15; kv = 4'd9; cv = 4'd13;
         end else begin
            rv = ($urandom_range(0, 99) < 5) ? DIM_W'($urandom_range(0, 15))
                                             : DIM_W'($urandom_range(1, 4));
            kv = ($urandom_range(0, 99) < 5) ? DIM_W'($urandom_range(0, 15))
                                             : DIM_W'($urandom_range(1, 4));
            cv = ($urandom_range(0, 99) < 5) ? DIM_W'($urandom_range(0, 15))
                                             : DIM_W'($urandom_range(1, 4));
         end
         write_reg(CSR_ROWS_FIRST, rv);
         write_reg(CSR_INNER_SIZE, kv);
         write_reg(CSR_COLS_SECOND, cv);
         if ($urandom_range(0, 4) == 0)
            write_reg(CSR_SPARE, DIM_W'($urandom_range(0, 15)));
         total = dim_in_use(rv) * dim_in_use(kv) + dim_in_use(kv) * dim_in_use(cv);
         repeat ((phase < 2) ? 1 : $urandom_range(1, 3)) begin
            // broken load: part of a pair, then a size write restarts it
            if ($urandom_range(0, 9) == 0) begin
               cut = $urandom_range(1, total - 1);
               repeat (cut) send_word(pick_element());
               write_reg(CSR_INNER_SIZE, kv);
            end
            repeat (total) send_word(pick_element());
            // hold back-to-back offers through the middle of the run
            gaps_on = !(words_sent >= 200 && words_sent < 300);
         end
         phase++;
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
